FILE: sv/assert_macros.svh
// Assertion macros for the delta varint sample decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/dvsd_pkg.sv
// Types and constants for the delta varint sample decoder.
package dvsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned MAG_W    = 20;
    localparam int unsigned COUNT_W  = 16;

    localparam logic [COUNT_W-1:0] SPB_RESET = 16'd512;

    // Position of the next byte within its group
    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2
    } pos_t;

    // Decoder status seen by the top level
    typedef struct packed {
        logic               load;
        logic               last;
        logic [COUNT_W-1:0] count;
        pos_t               pos;
    } dvsd_status_t;

endpackage

FILE: sv/dvsd_byte_if.sv
// Byte stream channel: valid/ready handshake carrying one compressed byte.
interface dvsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: sv/dvsd_sample_if.sv
// Sample channel: valid/ready handshake carrying one decoded sample.
interface dvsd_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               last_of_block;

    modport source (output valid, output sample, output last_of_block, input ready);
    modport sink   (input valid, input sample, input last_of_block, output ready);
endinterface

FILE: sv/dvsd_in_stage.sv
// Input register: holds one accepted byte until the decode stage takes it.
module dvsd_in_stage
    import dvsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dvsd_byte_if.sink   up,
    dvsd_byte_if.source down
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    // Refill in the same cycle the held word leaves
    assign up.ready = !valid_reg || down.ready;
    assign take     = up.valid && up.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (down.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= up.data_byte;
        end
    end

    assign down.valid     = valid_reg;
    assign down.data_byte = byte_reg;

endmodule

FILE: sv/dvsd_decode.sv
// Decode stage: group assembly, running sum, block counter and result register.
module dvsd_decode
    import dvsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    dvsd_byte_if.sink          up,
    dvsd_sample_if.source      down,
    output dvsd_status_t       stat
);

    logic [COUNT_W-1:0]  spb_reg;
    pos_t                pos_reg, pos_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [SAMPLE_W-1:0] sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic                out_last_reg;

    logic [BYTE_W-1:0]   b;
    logic [MAG_W-1:0]    mag_acc;
    logic                neg_cur;
    logic                done;
    logic [SAMPLE_W-1:0] diff;
    logic [SAMPLE_W-1:0] sum;
    logic [COUNT_W:0]    count_inc;
    logic                last;
    logic                out_free;
    logic                consume;
    logic                load;

    assign b = up.data_byte;

    always_comb
    begin
        neg_cur = neg_reg;
        unique case (pos_reg)
            POS_SECOND:
            begin
                mag_acc = mag_reg | {7'd0, b[6:0], 6'd0};
                done    = !b[7];
            end
            POS_THIRD:
            begin
                // third byte always closes the group
                mag_acc = mag_reg | {b[6:0], 13'd0};
                done    = 1'b1;
            end
            default:
            begin
                neg_cur = b[0];
                mag_acc = {14'd0, b[6:1]};
                done    = !b[7];
            end
        endcase
    end

    assign diff      = neg_cur ? (SAMPLE_W'(0) - {12'd0, mag_acc}) : {12'd0, mag_acc};
    assign sum       = sum_reg + diff;
    assign count_inc = {1'b0, count_reg} + 17'd1;
    assign last      = count_inc >= {1'b0, spb_reg};

    assign out_free  = !out_valid_reg || down.ready;
    assign consume   = up.valid && (!done || out_free);
    assign load      = consume && done;
    assign up.ready  = !done || out_free;

    always_comb
    begin
        pos_next   = pos_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (consume)
        begin
            if (done)
            begin
                pos_next   = POS_FIRST;
                mag_next   = '0;
                neg_next   = 1'b0;
                sum_next   = last ? '0 : sum;
                count_next = last ? '0 : count_inc[COUNT_W-1:0];
            end
            else
            begin
                pos_next = (pos_reg == POS_SECOND) ? POS_THIRD : POS_SECOND;
                mag_next = mag_acc;
                neg_next = neg_cur;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (down.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg       <= SPB_RESET;
            pos_reg       <= POS_FIRST;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                spb_reg <= cfg_wdata;
            end
            pos_reg       <= pos_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_sample_reg <= sum;
            out_last_reg   <= last;
        end
    end

    assign down.valid         = out_valid_reg;
    assign down.sample        = $signed(out_sample_reg);
    assign down.last_of_block = out_last_reg;

    assign stat.load  = load;
    assign stat.last  = last;
    assign stat.count = count_reg;
    assign stat.pos   = pos_reg;

endmodule

FILE: sv/delta_varint_sample_decoder_top.sv
// Top level of the delta varint sample decoder.
// Takes one compressed byte per cycle on bytes and gives one sample on samples for each
// group of one to three bytes; a byte passes the input register, and the sample of the
// group it closes is loaded into the result register. Sustained rate is one byte per
// cycle, set by the single decode stage whose longest path is the 32-bit running-sum add.
// A full result register holds back only bytes that close a group. samples_per_block
// must be written through cfg_we/cfg_wdata only while the block is idle; the block does
// not enforce this. 0 acts as 1. The running sum restarts after a last_of_block sample.
`include "assert_macros.svh"

module delta_varint_sample_decoder_top
    import dvsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    dvsd_byte_if.sink          bytes,
    dvsd_sample_if.source      samples,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    dvsd_byte_if  s1 ();
    dvsd_status_t stat;

    dvsd_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (bytes),
        .down  (s1)
    );

    dvsd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .up        (s1),
        .down      (samples),
        .stat      (stat)
    );

    // a result can only be loaded from a held word
    `ASSERT_ALWAYS(a_load_has_word, clk, rst_n, !stat.load || s1.valid, "load without word")
    `ASSERT_NEXT(a_accept_fills, clk, rst_n, bytes.valid && bytes.ready, s1.valid, "word lost")
    `ASSERT_NEXT(a_group_restarts, clk, rst_n, stat.load, stat.pos == POS_FIRST, "group not closed")
    `ASSERT_NEXT(a_block_restarts, clk, rst_n, stat.load && stat.last, stat.count == '0, "count not cleared")

endmodule

FILE: tb/tb.sv
// Testbench for the delta varint sample decoder: scoreboard prediction of every decoded sample.
`timescale 1ns / 100ps

module tb;
    import dvsd_pkg::*;

    localparam int unsigned SECOND_SHIFT = 6;
    localparam int unsigned THIRD_SHIFT  = 13;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned BIG_GROUPS    = 50;

    // Predicts decoded samples from accepted bytes and checks them in order
    class sample_scoreboard;
        typedef struct {
            logic signed [SAMPLE_W-1:0] sample;
            logic                       last;
        } sample_exp_t;

        logic [COUNT_W-1:0]  block_size;
        logic [SAMPLE_W-1:0] running_sum;
        logic [MAG_W-1:0]    magnitude;
        pos_t                pos;
        logic                negative;
        logic [COUNT_W-1:0]  count;
        sample_exp_t         expected_samples[$];
        int unsigned         errors;

        function new();
            block_size  = SPB_RESET;
            running_sum = '0;
            magnitude   = '0;
            pos         = POS_FIRST;
            negative    = 1'b0;
            count       = '0;
            errors      = 0;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b);
            logic                closes;
            logic [SAMPLE_W-1:0] diff;
            logic [SAMPLE_W-1:0] sum;
            logic                last;
            sample_exp_t         e;
            closes = 1'b0;
            case (pos)
                POS_SECOND:
                begin
                    magnitude |= MAG_W'(b[6:0]) << SECOND_SHIFT;
                    if (b[7])
                        pos = POS_THIRD;
                    else
                        closes = 1'b1;
                end
                POS_THIRD:
                begin
                    // third byte ends the group whatever bit 7 holds
                    magnitude |= MAG_W'(b[6:0]) << THIRD_SHIFT;
                    closes = 1'b1;
                end
                default:
                begin
                    negative  = b[0];
                    magnitude = MAG_W'(b[6:1]);
                    if (b[7])
                        pos = POS_SECOND;
                    else
                        closes = 1'b1;
                end
            endcase
            if (!closes)
                return;
            diff = {{(SAMPLE_W-MAG_W){1'b0}}, magnitude};
            if (negative)
                diff = -diff;
            sum  = running_sum + diff;
            // a block size of zero behaves as one
            last = ({1'b0, count} + 17'd1) >= {1'b0, block_size};
            e.sample = sum;
            e.last   = last;
            expected_samples.push_back(e);
            if (last)
            begin
                running_sum = '0;
                count       = '0;
            end
            else
            begin
                running_sum = sum;
                count       = count + 1'b1;
            end
            pos       = POS_FIRST;
            magnitude = '0;
            negative  = 1'b0;
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] s, logic l);
            sample_exp_t e;
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected word sample=%0d last=%0b", $time, s, l);
                errors++;
                return;
            end
            e = expected_samples.pop_front();
            if (s !== e.sample)
            begin
                $display("%0t: sample expected %0d got %0d", $time, e.sample, s);
                errors++;
            end
            if (l !== e.last)
            begin
                $display("%0t: last_of_block expected %0b got %0b", $time, e.last, l);
                errors++;
            end
        endfunction

        function bit mid_group();
            return pos != POS_FIRST;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    int unsigned        src_idle_pct;
    int unsigned        snk_idle_pct;
    sample_scoreboard   sb;

    dvsd_byte_if   byte_ch ();
    dvsd_sample_if sample_ch ();

    delta_varint_sample_decoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (byte_ch.sink),
        .samples   (sample_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver back-pressure
    initial
    begin
        sample_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            sample_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
            sb.check_sample(sample_ch.sample, sample_ch.last_of_block);
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        sb.take_byte(b);
    endtask

    // finish any open group with a closing byte so the decoder is between groups
    task automatic close_group();
        while (sb.mid_group())
            send_byte(BYTE_W'($urandom_range(127)));
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_block_size(input logic [COUNT_W-1:0] v);
        close_group();
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.block_size = v;
        @(posedge clk);
    endtask

    // mostly well-formed groups of random content, some raw noise bytes
    task automatic send_random_stream(input int unsigned n);
        int unsigned   sent;
        int unsigned   len;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_byte(BYTE_W'($urandom_range(255)));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                begin
                    b = BYTE_W'($urandom_range(255));
                    if (i < len - 1)
                        b[7] = 1'b1;
                    else if (i < 2)
                        b[7] = 1'b0;
                    send_byte(b);
                    sent++;
                end
            end
            if (sent == n / 2 && $urandom_range(1) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        logic [BYTE_W-1:0] directed_bytes[$];
        sb = new();
        src_idle_pct = 10;
        snk_idle_pct = 68;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, negative zero, largest one-byte values, three-byte groups, two-byte groups
        directed_bytes = '{8'h00, 8'h01, 8'h7E, 8'h7F,
                           8'hFE, 8'hFF, 8'hFF,
                           8'hFF, 8'hFF, 8'h7F,
                           8'h81, 8'h00, 8'h80, 8'h7F,
                           8'hFE, 8'h80, 8'h00,
                           8'h55, 8'hAA, 8'h55};
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        write_block_size(16'd0);
        send_byte(8'h02);
        send_byte(8'h05);
        send_byte(8'h81);
        send_byte(8'h01);
        write_block_size(16'd1);
        send_byte(8'h04);
        send_byte(8'h03);

        write_block_size(16'($urandom_range(2, 6)));
        send_random_stream(200);

        // largest differences build up over one long block
        src_idle_pct = 68;
        snk_idle_pct = 10;
        write_block_size(16'd65535);
        for (int i = 0; i < BIG_GROUPS; i++)
        begin
            send_byte(8'hFE);
            send_byte(8'hFF);
            send_byte(8'h7F);
        end
        // lowered below the current count: next sample closes the block
        write_block_size(16'd3);
        send_byte(8'h10);
        send_byte(8'h11);
        write_block_size(16'($urandom_range(1, 40)));
        send_random_stream(200);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_block_size(16'($urandom_range(1, 4)));
        send_random_stream(200);
        write_block_size(SPB_RESET);
        send_random_stream(20);

        close_group();
        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/dvsd_pkg.sv
sv/dvsd_byte_if.sv
sv/dvsd_sample_if.sv
sv/dvsd_in_stage.sv
sv/dvsd_decode.sv
sv/delta_varint_sample_decoder_top.sv
tb/tb.sv
